/* hw/rtl/fbg_pkg.sv */
// Shared constants for the four corner bilinear gradient core.
`default_nettype none
package fbg_pkg;

  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int SIZE_CFG_W = 13;
  localparam int COORD_W    = 12;
  localparam int CHAN_W     = 8;
  localparam int NUM_CHAN   = 3;
  localparam int COLOR_W    = NUM_CHAN * CHAN_W;

  // 255.99/255 scaling written as an exact integer ratio
  localparam int SCALE_NUM   = 25599;
  localparam int SCALE_DEN   = 25500;
  localparam int SCALE_NUM_W = 15;
  localparam int SCALE_DEN_W = 15;

  localparam int WIDTH_RESET  = 256;
  localparam int HEIGHT_RESET = 256;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH       = 3'd0,
    REG_IMAGE_HEIGHT      = 3'd1,
    REG_UPPER_LEFT_COLOR  = 3'd2,
    REG_UPPER_RIGHT_COLOR = 3'd3,
    REG_LOWER_LEFT_COLOR  = 3'd4,
    REG_LOWER_RIGHT_COLOR = 3'd5
  } reg_index_t;

endpackage
`default_nettype wire

/* hw/rtl/fbg_weights.sv */
// Size clamp, coordinate saturation and the four bilinear corner weights (two stages).
`default_nettype none
module fbg_weights
  import fbg_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096,
  parameter int WW = $clog2(MAX_WIDTH + 1),
  parameter int HW = $clog2(MAX_HEIGHT + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  en,
  input  wire logic                  in_valid,
  input  wire logic [COORD_W-1:0]    col,
  input  wire logic [COORD_W-1:0]    row,
  input  wire logic [SIZE_CFG_W-1:0] width_cfg,
  input  wire logic [SIZE_CFG_W-1:0] height_cfg,
  output logic                       valid,
  output logic [WW+HW-1:0]           wll,
  output logic [WW+HW-1:0]           wul,
  output logic [WW+HW-1:0]           wlr,
  output logic [WW+HW-1:0]           wur,
  output logic [WW+HW-1:0]           area
);

  logic [WW-1:0] w_eff, c_sat;
  logic [HW-1:0] h_eff, r_sat;
  logic [31:0]   wc32, hc32;

  logic          v1;
  logic [WW-1:0] w1, c1, wd1;
  logic [HW-1:0] h1, r1, hd1;

  always_comb begin
    wc32 = 32'(width_cfg);
    hc32 = 32'(height_cfg);
    if (wc32 == 32'd0) w_eff = WW'(1);
    else if (wc32 > 32'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(wc32);
    if (hc32 == 32'd0) h_eff = HW'(1);
    else if (hc32 > 32'(MAX_HEIGHT)) h_eff = HW'(MAX_HEIGHT);
    else h_eff = HW'(hc32);
    if (32'(col) >= 32'(w_eff)) c_sat = w_eff - WW'(1);
    else c_sat = WW'(col);
    if (32'(row) >= 32'(h_eff)) r_sat = h_eff - HW'(1);
    else r_sat = HW'(row);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      valid <= 1'b0;
    end else if (en) begin
      v1    <= in_valid;
      valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w1   <= w_eff;
      h1   <= h_eff;
      c1   <= c_sat;
      r1   <= r_sat;
      wd1  <= w_eff - c_sat;
      hd1  <= h_eff - r_sat;
      wll  <= (WW+HW)'(hd1) * (WW+HW)'(wd1);
      wul  <= (WW+HW)'(r1) * (WW+HW)'(wd1);
      wlr  <= (WW+HW)'(hd1) * (WW+HW)'(c1);
      wur  <= (WW+HW)'(r1) * (WW+HW)'(c1);
      area <= (WW+HW)'(w1) * (WW+HW)'(h1);
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/fbg_blend.sv */
// Weighted corner sum per channel, then scaling of numerator and divisor (two stages).
`default_nettype none
module fbg_blend
  import fbg_pkg::*;
#(
  parameter int PW = 26
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire logic               in_valid,
  input  wire logic [PW-1:0]      wll,
  input  wire logic [PW-1:0]      wul,
  input  wire logic [PW-1:0]      wlr,
  input  wire logic [PW-1:0]      wur,
  input  wire logic [PW-1:0]      area,
  input  wire logic [COLOR_W-1:0] ul_color,
  input  wire logic [COLOR_W-1:0] ur_color,
  input  wire logic [COLOR_W-1:0] ll_color,
  input  wire logic [COLOR_W-1:0] lr_color,
  output logic                    valid,
  output logic [PW+8+SCALE_NUM_W-1:0] num [NUM_CHAN],
  output logic [PW+SCALE_DEN_W-1:0]   den
);

  localparam int NW = PW + 8;

  logic              v3;
  logic [NW-1:0]     n3 [NUM_CHAN];
  logic [PW+SCALE_DEN_W-1:0] den3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3    <= 1'b0;
      valid <= 1'b0;
    end else if (en) begin
      v3    <= in_valid;
      valid <= v3;
    end
  end

  // channel k sits at bits 23-8k .. 16-8k
  for (genvar k = 0; k < NUM_CHAN; k++) begin : g_chan
    localparam int LSB = (NUM_CHAN - 1 - k) * CHAN_W;
    always_ff @(posedge clk) begin
      if (en) begin
        n3[k]  <= NW'(ll_color[LSB +: CHAN_W]) * NW'(wll)
                + NW'(ul_color[LSB +: CHAN_W]) * NW'(wul)
                + NW'(lr_color[LSB +: CHAN_W]) * NW'(wlr)
                + NW'(ur_color[LSB +: CHAN_W]) * NW'(wur);
        num[k] <= (NW+SCALE_NUM_W)'(n3[k]) * (NW+SCALE_NUM_W)'(SCALE_NUM);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den3 <= (PW+SCALE_DEN_W)'(area) * (PW+SCALE_DEN_W)'(SCALE_DEN);
      den  <= den3;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/fbg_divide.sv */
// Restoring divider, one quotient bit per stage, three channels sharing one divisor.
`default_nettype none
module fbg_divide
  import fbg_pkg::*;
#(
  parameter int PW = 26
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         en,
  input  wire logic                         in_valid,
  input  wire logic [PW+8+SCALE_NUM_W-1:0]  num [NUM_CHAN],
  input  wire logic [PW+SCALE_DEN_W-1:0]    den,
  output logic                              valid,
  output logic [CHAN_W-1:0]                 quo [NUM_CHAN]
);

  localparam int XW = PW + 8 + SCALE_NUM_W;
  localparam int DW = PW + SCALE_DEN_W;

  // quotient never exceeds 255, so CHAN_W stages suffice
  logic          v   [CHAN_W+1];
  logic [DW-1:0] d   [CHAN_W+1];
  logic [XW-1:0] rem [CHAN_W+1][NUM_CHAN];
  logic [CHAN_W-1:0] q [CHAN_W+1][NUM_CHAN];

  assign v[0] = in_valid;
  assign d[0] = den;
  for (genvar k = 0; k < NUM_CHAN; k++) begin : g_in
    assign rem[0][k] = num[k];
    assign q[0][k]   = '0;
  end

  for (genvar s = 0; s < CHAN_W; s++) begin : g_stage
    localparam int B = CHAN_W - 1 - s;
    always_ff @(posedge clk) begin
      if (rst) v[s+1] <= 1'b0;
      else if (en) v[s+1] <= v[s];
    end
    always_ff @(posedge clk) begin
      if (en) d[s+1] <= d[s];
    end
    for (genvar k = 0; k < NUM_CHAN; k++) begin : g_ch
      logic [XW-1:0] dsh;
      logic          fit;
      assign dsh = XW'(d[s]) << B;
      assign fit = rem[s][k] >= dsh;
      always_ff @(posedge clk) begin
        if (en) begin
          rem[s+1][k] <= fit ? rem[s][k] - dsh : rem[s][k];
          q[s+1][k]   <= q[s][k] | (fit ? CHAN_W'(1) << B : CHAN_W'(0));
        end
      end
    end
  end

  assign valid = v[CHAN_W];
  for (genvar k = 0; k < NUM_CHAN; k++) begin : g_out
    assign quo[k] = q[CHAN_W][k];
  end

endmodule
`default_nettype wire

/* hw/rtl/four_corner_bilinear_gradient_core.sv */
// Top level of the four corner bilinear gradient core: config registers and pipeline.
//
// Usage:
//   Pixel items (pixel_column, pixel_row) enter on pixel_valid/pixel_stall; one
//   color item (red_out, green_out, blue_out) leaves on color_valid/color_stall
//   for every pixel item, in order. Row 0 is the bottom edge, column 0 the left.
//   Registers are written through cfg_write/cfg_index/cfg_data; indexes 6 and 7
//   are ignored. Write only while no item is in flight; the core does not enforce it.
//   Two stages do clamping and corner weights, two the weighted sum and scaling,
//   eight the one-bit-per-stage divider. The divider chain is fully pipelined.
//   Throughput is one item per clock unless color_stall freezes the pipeline.
//   When color_valid is high and color_stall is high the whole pipeline
//   freezes and pixel_stall goes high in the same cycle; nothing is lost.
//   Reset (rst, synchronous) empties the pipeline and sets width and height
//   to 256 and all corner colors to black.
`default_nettype none
module four_corner_bilinear_gradient_core
  import fbg_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  pixel_valid,
  output logic                       pixel_stall,
  input  wire logic [COORD_W-1:0]    pixel_column,
  input  wire logic [COORD_W-1:0]    pixel_row,
  output logic                       color_valid,
  input  wire logic                  color_stall,
  output logic [CHAN_W-1:0]          red_out,
  output logic [CHAN_W-1:0]          green_out,
  output logic [CHAN_W-1:0]          blue_out
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int PW = WW + HW;

  logic [SIZE_CFG_W-1:0] image_width, image_height;
  logic [COLOR_W-1:0]    upper_left_color, upper_right_color;
  logic [COLOR_W-1:0]    lower_left_color, lower_right_color;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width       <= SIZE_CFG_W'(WIDTH_RESET);
      image_height      <= SIZE_CFG_W'(HEIGHT_RESET);
      upper_left_color  <= '0;
      upper_right_color <= '0;
      lower_left_color  <= '0;
      lower_right_color <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:       image_width       <= cfg_data[SIZE_CFG_W-1:0];
        REG_IMAGE_HEIGHT:      image_height      <= cfg_data[SIZE_CFG_W-1:0];
        REG_UPPER_LEFT_COLOR:  upper_left_color  <= cfg_data;
        REG_UPPER_RIGHT_COLOR: upper_right_color <= cfg_data;
        REG_LOWER_LEFT_COLOR:  lower_left_color  <= cfg_data;
        REG_LOWER_RIGHT_COLOR: lower_right_color <= cfg_data;
        default: ;
      endcase
    end
  end

  // single pipeline-wide advance; the last divider stage is the output register
  logic en;
  assign en          = !(color_valid && color_stall);
  assign pixel_stall = !en;

  logic          wt_valid;
  logic [PW-1:0] wll, wul, wlr, wur, area;

  fbg_weights #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .WW        (WW),
    .HW        (HW)
  ) u_weights (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (pixel_valid),
    .col       (pixel_column),
    .row       (pixel_row),
    .width_cfg (image_width),
    .height_cfg(image_height),
    .valid     (wt_valid),
    .wll       (wll),
    .wul       (wul),
    .wlr       (wlr),
    .wur       (wur),
    .area      (area)
  );

  logic                         bl_valid;
  logic [PW+8+SCALE_NUM_W-1:0]  num [NUM_CHAN];
  logic [PW+SCALE_DEN_W-1:0]    den;

  fbg_blend #(.PW(PW)) u_blend (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_valid(wt_valid),
    .wll     (wll),
    .wul     (wul),
    .wlr     (wlr),
    .wur     (wur),
    .area    (area),
    .ul_color(upper_left_color),
    .ur_color(upper_right_color),
    .ll_color(lower_left_color),
    .lr_color(lower_right_color),
    .valid   (bl_valid),
    .num     (num),
    .den     (den)
  );

  logic [CHAN_W-1:0] quo [NUM_CHAN];

  fbg_divide #(.PW(PW)) u_divide (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_valid(bl_valid),
    .num     (num),
    .den     (den),
    .valid   (color_valid),
    .quo     (quo)
  );

  assign red_out   = quo[0];
  assign green_out = quo[1];
  assign blue_out  = quo[2];

endmodule
`default_nettype wire
